// ----- rtl/core/assert_macros.svh -----
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define LAVM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define LAVM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/lavm_pkg.sv -----
package lavm_pkg;

  localparam int unsigned DW = 32;
  localparam int unsigned AW = 34;
  localparam int unsigned CW = 2 * AW + 1;
  localparam int unsigned SAT_W = 70;
  localparam int unsigned NORM_MSB = 29;

  localparam logic [3:0] SEED_BASE = 4'd4;
  localparam logic [3:0] SEED_LAST = 4'd11;
  localparam logic [31:0] THREE_Q30 = 32'hC000_0000;

  localparam logic [1:0] ROW_R = 2'd0;
  localparam logic [1:0] ROW_U = 2'd1;
  localparam logic [1:0] ROW_F = 2'd2;
  localparam logic [1:0] ROW_H = 2'd3;

  typedef logic signed [AW-1:0] axis_t;
  typedef axis_t [2:0] vec_t;

  typedef struct packed {
    vec_t v;
    logic zero;
  } norm_res_t;

  function automatic int unsigned norm_latency(input int unsigned iters);
    return 7 + 3 * iters;
  endfunction

  function automatic logic [15:0] rsqrt_seed(input logic [3:0] idx);
    logic [15:0] s;
    unique case (idx)
      4'd0:    s = 16'd61788;
      4'd1:    s = 16'd55889;
      4'd2:    s = 16'd51411;
      4'd3:    s = 16'd47861;
      4'd4:    s = 16'd44957;
      4'd5:    s = 16'd42525;
      4'd6:    s = 16'd40450;
      4'd7:    s = 16'd38651;
      4'd8:    s = 16'd37073;
      4'd9:    s = 16'd35674;
      4'd10:   s = 16'd34422;
      default: s = 16'd33292;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic [31:0] r;
    if ((&v[SAT_W-1:31]) || !(|v[SAT_W-1:31])) begin
      r = v[31:0];
    end else if (v[SAT_W-1]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/lavm_in_if.sv -----
interface lavm_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] eye_x;
  logic [31:0] eye_y;
  logic [31:0] eye_z;
  logic [31:0] target_x;
  logic [31:0] target_y;
  logic [31:0] target_z;
  logic [31:0] up_x;
  logic [31:0] up_y;
  logic [31:0] up_z;

  modport source (
    output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z,
    input  ready
  );
  modport sink (
    input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z,
    output ready
  );
endinterface

// ----- rtl/core/lavm_out_if.sv -----
interface lavm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  row_index;
  logic [31:0] col0;
  logic [31:0] col1;
  logic [31:0] col2;
  logic [31:0] col3;
  logic        last_row;
  logic        degenerate;

  modport source (
    output valid, row_index, col0, col1, col2, col3, last_row, degenerate,
    input  ready
  );
  modport sink (
    input  valid, row_index, col0, col1, col2, col3, last_row, degenerate,
    output ready
  );
endinterface

// ----- rtl/core/lavm_delay.sv -----
module lavm_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule

// ----- rtl/core/lavm_rsqrt.sv -----
module lavm_rsqrt import lavm_pkg::*; #(
  parameter int unsigned ITERATIONS = 3
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] x_i,
  output logic [31:0] y_o
);

  logic [31:0] y_q [ITERATIONS+1];
  logic [31:0] x_q [ITERATIONS];
  logic [3:0]  idx;

  assign idx = (x_i[31:28] < SEED_BASE) ? SEED_LAST : x_i[31:28] - SEED_BASE;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= x_i;
      y_q[0] <= {2'b00, rsqrt_seed(idx), 14'b0};
    end
  end

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
    logic [63:0] sq;
    logic [63:0] tp;
    logic [63:0] yp;
    logic [33:0] t;
    logic [31:0] h_d;
    logic [31:0] y2_q;
    logic [31:0] ya_q;
    logic [31:0] yb_q;
    logic [31:0] xa_q;
    logic [31:0] h_q;

    assign sq = 64'(y_q[k]) * 64'(y_q[k]);
    assign tp = 64'(xa_q) * 64'(y2_q);
    assign t  = tp[63:30];
    assign h_d = (t > 34'(THREE_Q30)) ? 32'd0 : 32'(34'(THREE_Q30) - t);
    assign yp = 64'(yb_q) * 64'(h_q);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        y2_q <= sq[61:30];
        ya_q <= y_q[k];
        xa_q <= x_q[k];
        h_q  <= h_d;
        yb_q <= ya_q;
        y_q[k+1] <= yp[62:31];
      end
    end

    if (k + 1 < ITERATIONS) begin : g_x
      logic [31:0] xb_q;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          xb_q     <= xa_q;
          x_q[k+1] <= xb_q;
        end
      end
    end
  end

  assign y_o = y_q[ITERATIONS];

endmodule

// ----- rtl/core/lavm_norm.sv -----
module lavm_norm import lavm_pkg::*; #(
  parameter int unsigned IW = 33,
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned ITERATIONS = 3
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [2:0][IW-1:0] vec_i,
  output norm_res_t          res_o
);

  localparam int unsigned PW = $clog2(IW);
  localparam logic [PW-1:0] TOP_BIT = PW'(NORM_MSB);
  localparam int unsigned RL = 1 + 3 * ITERATIONS;
  localparam int unsigned SH_LO = 59 - FRAC_BITS;
  localparam int unsigned SH_HI = 60 - FRAC_BITS;
  localparam logic [62:0] HALF_LO = 63'(1) << (SH_LO - 1);
  localparam logic [62:0] HALF_HI = 63'(1) << (SH_HI - 1);
  localparam int unsigned SIDE_W = 3 * 30 + 5;

  logic [2:0][IW-1:0] m1_d, m1_q, m2_q;
  logic [2:0]         s1_q, s2_q, s3_q, s4_q, s5_q, s6;
  logic [IW-1:0]      or1_q;
  logic [PW-1:0]      p2_d, p2_q;
  logic               z2_d, z2_q, z3_q, z4_q, z5_q, z6;
  logic [2:0][29:0]   c3_d, c3_q, c4_q, c5_q, c6;
  logic [2:0][59:0]   sq4_q;
  logic [61:0]        sum5;
  logic [31:0]        x5_q;
  logic               q5_q, q6;
  logic [31:0]        r6;
  logic [SIDE_W-1:0]  side_d, side_q;
  norm_res_t          res_d, res_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m1_d[i] = vec_i[i][IW-1] ? (~vec_i[i] + 1'b1) : vec_i[i];
    end
  end

  always_comb begin
    p2_d = '0;
    for (int i = 0; i < IW; i++) begin
      if (or1_q[i]) begin
        p2_d = PW'(i);
      end
    end
    z2_d = ~|or1_q;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (p2_q >= TOP_BIT) begin
        c3_d[i] = 30'(m2_q[i] >> (p2_q - TOP_BIT));
      end else begin
        c3_d[i] = 30'(m2_q[i] << (TOP_BIT - p2_q));
      end
    end
  end

  assign sum5 = 62'(sq4_q[0]) + 62'(sq4_q[1]) + 62'(sq4_q[2]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q  <= m1_d;
      for (int i = 0; i < 3; i++) begin
        s1_q[i] <= vec_i[i][IW-1];
      end
      or1_q <= m1_d[0] | m1_d[1] | m1_d[2];
      m2_q  <= m1_q;
      s2_q  <= s1_q;
      p2_q  <= p2_d;
      z2_q  <= z2_d;
      c3_q  <= c3_d;
      s3_q  <= s2_q;
      z3_q  <= z2_q;
      for (int i = 0; i < 3; i++) begin
        sq4_q[i] <= 60'(c3_q[i]) * 60'(c3_q[i]);
      end
      c4_q  <= c3_q;
      s4_q  <= s3_q;
      z4_q  <= z3_q;
      q5_q  <= |sum5[61:60];
      x5_q  <= (|sum5[61:60]) ? sum5[61:30] : sum5[59:28];
      c5_q  <= c4_q;
      s5_q  <= s4_q;
      z5_q  <= z4_q;
      res_q <= res_d;
    end
  end

  lavm_rsqrt #(
    .ITERATIONS(ITERATIONS)
  ) u_rsqrt (
    .clk_i(clk_i),
    .en_i (en_i),
    .x_i  (x5_q),
    .y_o  (r6)
  );

  assign side_d = {c5_q, s5_q, z5_q, q5_q};

  lavm_delay #(
    .WIDTH(SIDE_W),
    .DEPTH(RL)
  ) u_side (
    .clk_i(clk_i),
    .en_i (en_i),
    .d_i  (side_d),
    .q_o  (side_q)
  );

  assign {c6, s6, z6, q6} = side_q;

  always_comb begin
    logic [62:0] prod;
    logic [62:0] rnd;
    logic [62:0] u;
    logic [AW-1:0] ua;
    res_d.zero = z6;
    for (int i = 0; i < 3; i++) begin
      prod = 63'(c6[i]) * 63'(r6);
      rnd  = prod + (q6 ? HALF_HI : HALF_LO);
      u    = q6 ? (rnd >> SH_HI) : (rnd >> SH_LO);
      ua   = u[AW-1:0];
      if (z6) begin
        res_d.v[i] = '0;
      end else begin
        res_d.v[i] = s6[i] ? (~ua + 1'b1) : ua;
      end
    end
  end

  assign res_o = res_q;

endmodule

// ----- rtl/core/look_at_view_matrix_unit.sv -----
// Right-handed look-at view matrix in signed fixed point with FRAC_BITS fraction bits.
// Each accepted item (eye, target, up) yields four rows on the output channel, row 0 first,
// with the last one flagged; degenerate geometry gives zero rows 0 to 2 and the degenerate
// flag on all four. The pipeline takes one item per cycle while it is not stalled, and the sustained
// rate is set by the four rows the output register hands out, one per cycle while the output is
// ready; a stalled output holds the pipeline in place once its last stage holds an item.
module look_at_view_matrix_unit import lavm_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned RSQRT_ITERATIONS = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lavm_in_if.sink    in_i,
  lavm_out_if.source out_o
);

  localparam int unsigned LN = norm_latency(RSQRT_ITERATIONS);
  localparam int unsigned LT = 2 * LN + 7;
  localparam logic [CW-1:0] HALF_T = CW'(1) << (FRAC_BITS - 1);
  localparam logic [67:0] HALF_D = 68'(1) << (FRAC_BITS - 1);
  localparam logic [31:0] ONE_FIX = 32'(64'(1) << FRAC_BITS);
  localparam int unsigned BW = 3 * AW + 3 * DW + 1;

  logic en;
  logic ser_free;
  logic [LT-1:0] vld_q;

  logic [2:0][DW-1:0] eye0_q, up0_q;
  logic [2:0][DW:0]   d0_q;
  logic [3*DW-1:0]    eye_a;
  norm_res_t          nd, nu, nc;

  logic signed [67:0] xp_d [6];
  logic signed [67:0] xp_q [6];
  vec_t               fw_x1_q, fw_x2_q;
  logic [2:0][DW-1:0] eye_x1_q, eye_x2_q;
  logic               ok_x1_q, ok_x2_q;
  logic [2:0][CW-1:0] cr_q;

  logic [BW-1:0]      bun_d, bun_q;
  vec_t               fw_b;
  logic [2:0][DW-1:0] eye_b;
  logic               ok_b;

  logic signed [67:0] tp_d [6];
  logic signed [67:0] tp_q [6];
  vec_t               rt_t1_q, fw_t1_q, rt_t2_q, fw_t2_q, tu_d, tu_t2_q;
  logic [2:0][DW-1:0] eye_t1_q, eye_t2_q;
  logic               ok_t1_q, ok_t2_q, ok_d1_q;

  vec_t               ax_q [3];
  logic signed [65:0] dp_q [3][3];
  logic [2:0][3:0][31:0] row_d, row_q, ser_rows_q;
  logic               deg_q, ser_deg_q;

  logic               busy_q;
  logic [1:0]         row_idx_q;

  assign ser_free   = !busy_q || (out_o.ready && row_idx_q == ROW_H);
  assign en         = !vld_q[LT-1] || ser_free;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LT-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      eye0_q <= {in_i.eye_z, in_i.eye_y, in_i.eye_x};
      up0_q  <= {in_i.up_z, in_i.up_y, in_i.up_x};
      d0_q[0] <= {in_i.eye_x[31], in_i.eye_x} - {in_i.target_x[31], in_i.target_x};
      d0_q[1] <= {in_i.eye_y[31], in_i.eye_y} - {in_i.target_y[31], in_i.target_y};
      d0_q[2] <= {in_i.eye_z[31], in_i.eye_z} - {in_i.target_z[31], in_i.target_z};
    end
  end

  lavm_norm #(
    .IW(DW + 1), .FRAC_BITS(FRAC_BITS), .ITERATIONS(RSQRT_ITERATIONS)
  ) u_norm_fwd (
    .clk_i(clk_i), .en_i(en), .vec_i(d0_q), .res_o(nd)
  );

  lavm_norm #(
    .IW(DW), .FRAC_BITS(FRAC_BITS), .ITERATIONS(RSQRT_ITERATIONS)
  ) u_norm_up (
    .clk_i(clk_i), .en_i(en), .vec_i(up0_q), .res_o(nu)
  );

  lavm_delay #(
    .WIDTH(3 * DW), .DEPTH(LN)
  ) u_eye_a (
    .clk_i(clk_i), .en_i(en), .d_i(eye0_q), .q_o(eye_a)
  );

  always_comb begin
    xp_d[0] = $signed(nu.v[1]) * $signed(nd.v[2]);
    xp_d[1] = $signed(nu.v[2]) * $signed(nd.v[1]);
    xp_d[2] = $signed(nu.v[2]) * $signed(nd.v[0]);
    xp_d[3] = $signed(nu.v[0]) * $signed(nd.v[2]);
    xp_d[4] = $signed(nu.v[0]) * $signed(nd.v[1]);
    xp_d[5] = $signed(nu.v[1]) * $signed(nd.v[0]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xp_q     <= xp_d;
      fw_x1_q  <= nd.v;
      eye_x1_q <= eye_a;
      ok_x1_q  <= !nd.zero && !nu.zero;
      cr_q[0]  <= CW'(xp_q[0]) - CW'(xp_q[1]);
      cr_q[1]  <= CW'(xp_q[2]) - CW'(xp_q[3]);
      cr_q[2]  <= CW'(xp_q[4]) - CW'(xp_q[5]);
      fw_x2_q  <= fw_x1_q;
      eye_x2_q <= eye_x1_q;
      ok_x2_q  <= ok_x1_q;
    end
  end

  lavm_norm #(
    .IW(CW), .FRAC_BITS(FRAC_BITS), .ITERATIONS(RSQRT_ITERATIONS)
  ) u_norm_right (
    .clk_i(clk_i), .en_i(en), .vec_i(cr_q), .res_o(nc)
  );

  assign bun_d = {fw_x2_q, eye_x2_q, ok_x2_q};

  lavm_delay #(
    .WIDTH(BW), .DEPTH(LN)
  ) u_bundle (
    .clk_i(clk_i), .en_i(en), .d_i(bun_d), .q_o(bun_q)
  );

  assign {fw_b, eye_b, ok_b} = bun_q;

  always_comb begin
    tp_d[0] = $signed(fw_b[1]) * $signed(nc.v[2]);
    tp_d[1] = $signed(fw_b[2]) * $signed(nc.v[1]);
    tp_d[2] = $signed(fw_b[2]) * $signed(nc.v[0]);
    tp_d[3] = $signed(fw_b[0]) * $signed(nc.v[2]);
    tp_d[4] = $signed(fw_b[0]) * $signed(nc.v[1]);
    tp_d[5] = $signed(fw_b[1]) * $signed(nc.v[0]);
  end

  always_comb begin
    logic signed [CW-1:0] diff;
    logic [CW-1:0]        tm;
    logic [CW-1:0]        tr;
    logic [AW-1:0]        ta;
    for (int i = 0; i < 3; i++) begin
      diff = CW'(tp_q[2*i]) - CW'(tp_q[2*i+1]);
      tm   = diff[CW-1] ? (~diff + 1'b1) : diff;
      tr   = (tm + HALF_T) >> FRAC_BITS;
      ta   = tr[AW-1:0];
      tu_d[i] = diff[CW-1] ? (~ta + 1'b1) : ta;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tp_q     <= tp_d;
      rt_t1_q  <= nc.v;
      fw_t1_q  <= fw_b;
      eye_t1_q <= eye_b;
      ok_t1_q  <= ok_b && !nc.zero;
      tu_t2_q  <= tu_d;
      rt_t2_q  <= rt_t1_q;
      fw_t2_q  <= fw_t1_q;
      eye_t2_q <= eye_t1_q;
      ok_t2_q  <= ok_t1_q;
      ax_q[0]  <= rt_t2_q;
      ax_q[1]  <= tu_t2_q;
      ax_q[2]  <= fw_t2_q;
      ok_d1_q  <= ok_t2_q;
      for (int i = 0; i < 3; i++) begin
        dp_q[0][i] <= $signed(rt_t2_q[i]) * $signed(eye_t2_q[i]);
        dp_q[1][i] <= $signed(tu_t2_q[i]) * $signed(eye_t2_q[i]);
        dp_q[2][i] <= $signed(fw_t2_q[i]) * $signed(eye_t2_q[i]);
      end
      row_q <= row_d;
      deg_q <= !ok_d1_q;
    end
  end

  always_comb begin
    logic signed [67:0] dot;
    logic [67:0]        dm;
    logic [67:0]        rm;
    logic signed [SAT_W-1:0] tv;
    for (int k = 0; k < 3; k++) begin
      dot = 68'(dp_q[k][0]) + 68'(dp_q[k][1]) + 68'(dp_q[k][2]);
      dm  = dot[67] ? (~dot + 1'b1) : dot;
      rm  = (dm + HALF_D) >> FRAC_BITS;
      tv  = dot[67] ? $signed({2'b00, rm}) : -$signed({2'b00, rm});
      for (int i = 0; i < 3; i++) begin
        row_d[k][i] = ok_d1_q ? sat32(SAT_W'($signed(ax_q[k][i]))) : 32'd0;
      end
      row_d[k][3] = ok_d1_q ? sat32(tv) : 32'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_q[LT-1]) begin
      ser_rows_q <= row_q;
      ser_deg_q  <= deg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      row_idx_q <= ROW_R;
    end else if (en && vld_q[LT-1]) begin
      busy_q    <= 1'b1;
      row_idx_q <= ROW_R;
    end else if (out_o.valid && out_o.ready) begin
      if (row_idx_q == ROW_H) begin
        busy_q <= 1'b0;
      end else begin
        row_idx_q <= row_idx_q + 2'd1;
      end
    end
  end

  assign out_o.valid      = busy_q;
  assign out_o.row_index  = row_idx_q;
  assign out_o.last_row   = (row_idx_q == ROW_H);
  assign out_o.degenerate = ser_deg_q;

  always_comb begin
    unique case (row_idx_q)
      ROW_R: begin
        {out_o.col3, out_o.col2, out_o.col1, out_o.col0} = ser_rows_q[0];
      end
      ROW_U: begin
        {out_o.col3, out_o.col2, out_o.col1, out_o.col0} = ser_rows_q[1];
      end
      ROW_F: begin
        {out_o.col3, out_o.col2, out_o.col1, out_o.col0} = ser_rows_q[2];
      end
      default: begin
        out_o.col0 = 32'd0;
        out_o.col1 = 32'd0;
        out_o.col2 = 32'd0;
        out_o.col3 = ONE_FIX;
      end
    endcase
  end

endmodule

// ----- rtl/core/lavm_checker.sv -----
`include "assert_macros.svh"

module lavm_checker import lavm_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  row_index_i,
  input logic [31:0] col0_i,
  input logic [31:0] col1_i,
  input logic [31:0] col2_i,
  input logic [31:0] col3_i,
  input logic        last_row_i,
  input logic        degenerate_i
);

  localparam logic [31:0] ONE_FIX = 32'(64'(1) << FRAC_BITS);

  `LAVM_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "output item dropped while stalled")
  `LAVM_ASSERT(a_row_order, clk_i, rst_ni, out_valid_i && out_ready_i && row_index_i != ROW_H |=> out_valid_i && row_index_i == 2'($past(row_index_i) + 2'd1), "rows out of order")
  `LAVM_ASSERT_ALWAYS(a_last_row, clk_i, !out_valid_i || (last_row_i == (row_index_i == ROW_H)), "last row flag mismatch")
  `LAVM_ASSERT(a_row_three, clk_i, rst_ni, out_valid_i && row_index_i == ROW_H |-> col0_i == 32'd0 && col1_i == 32'd0 && col2_i == 32'd0 && col3_i == ONE_FIX, "bad homogeneous row")
  `LAVM_ASSERT(a_degenerate, clk_i, rst_ni, out_valid_i && degenerate_i && row_index_i != ROW_H |-> col0_i == 32'd0 && col1_i == 32'd0 && col2_i == 32'd0 && col3_i == 32'd0, "degenerate row not zero")

endmodule

bind look_at_view_matrix_unit lavm_checker #(
  .FRAC_BITS(FRAC_BITS)
) u_lavm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .row_index_i (out_o.row_index),
  .col0_i      (out_o.col0),
  .col1_i      (out_o.col1),
  .col2_i      (out_o.col2),
  .col3_i      (out_o.col3),
  .last_row_i  (out_o.last_row),
  .degenerate_i(out_o.degenerate)
);
